// ===== rtl/emts_pkg.sv =====
package emts_pkg;

   localparam int SCREEN_MAX_W_DEF = 2048;
   localparam int SCREEN_MAX_H_DEF = 2048;
   localparam int TEMPLATE_MAX_W_DEF = 256;
   localparam int TEMPLATE_MAX_H_DEF = 256;

   localparam int PIXEL_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 12;
   localparam int COORD_W = 11;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPLATE_WIDTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPLATE_HEIGHT = 2'd3;

   localparam logic OP_TEMPLATE = 1'b0;
   localparam logic OP_SCREEN = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/emts_ram.sv =====
module emts_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 24,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/exact_template_match_search.sv =====
// Template and screen pixels arrive one item per cycle while idle (op 0 template, op 1 screen),
// bottom row first, and are written into two single-port-write, registered-read memories. The
// screen pixel that completes width times height starts an exhaustive search (or, if the template
// exceeds the screen, a not-found result): each placement is tried row by row, pixel by pixel, each
// comparison being a read state then a compare state, stopping at the first mismatch and ending at
// the first full match. req_stall stays high until the one result item is taken.
module exact_template_match_search #(
   parameter int SCREEN_MAX_W = emts_pkg::SCREEN_MAX_W_DEF,
   parameter int SCREEN_MAX_H = emts_pkg::SCREEN_MAX_H_DEF,
   parameter int TEMPLATE_MAX_W = emts_pkg::TEMPLATE_MAX_W_DEF,
   parameter int TEMPLATE_MAX_H = emts_pkg::TEMPLATE_MAX_H_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [emts_pkg::PIXEL_W-1:0]        req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [emts_pkg::COORD_W-1:0]        rsp_match_x,
   output logic [emts_pkg::COORD_W-1:0]        rsp_match_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [emts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [emts_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SDEPTH = SCREEN_MAX_W * SCREEN_MAX_H;
   localparam int TDEPTH = TEMPLATE_MAX_W * TEMPLATE_MAX_H;
   localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
   localparam int TAW = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int SXW = $clog2(SCREEN_MAX_W + 1);
   localparam int SYW = $clog2(SCREEN_MAX_H + 1);
   localparam int TXW = $clog2(TEMPLATE_MAX_W + 1);
   localparam int TYW = $clog2(TEMPLATE_MAX_H + 1);
   localparam int TOTW = SXW + SYW;

   logic [11:0] scr_w_ff, scr_h_ff;
   logic [8:0]  tpl_w_ff, tpl_h_ff;

   logic [SXW-1:0] sw_c, sw_ff;
   logic [SYW-1:0] sh_c, sh_ff;
   logic [TXW-1:0] tw_c, tw_ff;
   logic [TYW-1:0] th_c, th_ff;
   logic [TOTW-1:0] total;

   emts_pkg::state_type state_ff, state_in;
   logic [SAW-1:0] swr_idx_ff, swr_idx_in;
   logic [TAW-1:0] twr_idx_ff, twr_idx_in;
   logic [SXW-1:0] x_ff, x_in;
   logic [SYW-1:0] y_ff, y_in;
   logic [TXW-1:0] tx_ff, tx_in;
   logic [TYW-1:0] ty_ff, ty_in;
   logic [SAW-1:0] row_base_ff, row_base_in;
   logic [SAW-1:0] origin_ff, origin_in;
   logic [SAW-1:0] srow_ff, srow_in;
   logic [SAW-1:0] sidx_ff, sidx_in;
   logic [TAW-1:0] tidx_ff, tidx_in;
   logic found_ff, found_in;
   logic [emts_pkg::COORD_W-1:0] mx_ff, mx_in, my_ff, my_in;

   logic accept;
   logic scr_wr, tpl_wr;
   logic [emts_pkg::PIXEL_W-1:0] scr_q, tpl_q;
   logic [31:0] flip_y;
   logic [31:0] x_wide;

   always_comb begin
      sw_c = (scr_w_ff == 12'd0) ? SXW'(1) :
             (32'(scr_w_ff) > SCREEN_MAX_W) ? SXW'(SCREEN_MAX_W) : SXW'(scr_w_ff);
      sh_c = (scr_h_ff == 12'd0) ? SYW'(1) :
             (32'(scr_h_ff) > SCREEN_MAX_H) ? SYW'(SCREEN_MAX_H) : SYW'(scr_h_ff);
      tw_c = (tpl_w_ff == 9'd0) ? TXW'(1) :
             (32'(tpl_w_ff) > TEMPLATE_MAX_W) ? TXW'(TEMPLATE_MAX_W) : TXW'(tpl_w_ff);
      th_c = (tpl_h_ff == 9'd0) ? TYW'(1) :
             (32'(tpl_h_ff) > TEMPLATE_MAX_H) ? TYW'(TEMPLATE_MAX_H) : TYW'(tpl_h_ff);
      total = TOTW'(sw_c) * TOTW'(sh_c);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= 12'd1920;
         scr_h_ff <= 12'd1080;
         tpl_w_ff <= 9'd16;
         tpl_h_ff <= 9'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            emts_pkg::REG_SCREEN_WIDTH:    scr_w_ff <= csr_data;
            emts_pkg::REG_SCREEN_HEIGHT:   scr_h_ff <= csr_data;
            emts_pkg::REG_TEMPLATE_WIDTH:  tpl_w_ff <= csr_data[8:0];
            emts_pkg::REG_TEMPLATE_HEIGHT: tpl_h_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != emts_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign scr_wr = accept && (req_op == emts_pkg::OP_SCREEN);
   assign tpl_wr = accept && (req_op == emts_pkg::OP_TEMPLATE);

   emts_ram #(.DEPTH(SDEPTH), .WIDTH(emts_pkg::PIXEL_W)) u_screen_ram (
      .clock   (clock),
      .wr_en   (scr_wr),
      .wr_addr (swr_idx_ff),
      .wr_data (req_pixel),
      .rd_addr (sidx_ff),
      .rd_data (scr_q)
   );

   emts_ram #(.DEPTH(TDEPTH), .WIDTH(emts_pkg::PIXEL_W)) u_template_ram (
      .clock   (clock),
      .wr_en   (tpl_wr),
      .wr_addr (twr_idx_ff),
      .wr_data (req_pixel),
      .rd_addr (tidx_ff),
      .rd_data (tpl_q)
   );

   always_comb begin
      state_in = state_ff;
      swr_idx_in = swr_idx_ff;
      twr_idx_in = twr_idx_ff;
      x_in = x_ff;
      y_in = y_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      row_base_in = row_base_ff;
      origin_in = origin_ff;
      srow_in = srow_ff;
      sidx_in = sidx_ff;
      tidx_in = tidx_ff;
      found_in = found_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      flip_y = 32'(sh_ff) - 32'(th_ff) - 32'(y_ff);
      x_wide = 32'(x_ff);

      unique case (state_ff)
         emts_pkg::ST_IDLE: begin
            if (tpl_wr) begin
               twr_idx_in = (32'(twr_idx_ff) + 1 >= TDEPTH) ? '0 : twr_idx_ff + TAW'(1);
            end
            if (scr_wr) begin
               if (TOTW'(32'(swr_idx_ff) + 1) >= total) begin
                  swr_idx_in = '0;
                  twr_idx_in = '0;
                  x_in = '0;
                  y_in = '0;
                  tx_in = '0;
                  ty_in = '0;
                  row_base_in = '0;
                  origin_in = '0;
                  srow_in = '0;
                  sidx_in = '0;
                  tidx_in = '0;
                  found_in = 1'b0;
                  mx_in = '0;
                  my_in = '0;
                  if ((32'(tw_c) > 32'(sw_c)) || (32'(th_c) > 32'(sh_c))) begin
                     state_in = emts_pkg::ST_RESULT;
                  end else begin
                     state_in = emts_pkg::ST_READ;
                  end
               end else begin
                  swr_idx_in = (32'(swr_idx_ff) + 1 >= SDEPTH) ? '0 : swr_idx_ff + SAW'(1);
               end
            end
         end
         emts_pkg::ST_READ: begin
            state_in = emts_pkg::ST_COMPARE;
         end
         emts_pkg::ST_COMPARE: begin
            state_in = emts_pkg::ST_READ;
            if (scr_q == tpl_q) begin
               if (32'(tx_ff) + 1 == 32'(tw_ff)) begin
                  if (32'(ty_ff) + 1 == 32'(th_ff)) begin
                     found_in = 1'b1;
                     mx_in = x_wide[emts_pkg::COORD_W-1:0];
                     my_in = flip_y[emts_pkg::COORD_W-1:0];
                     state_in = emts_pkg::ST_RESULT;
                  end else begin
                     tx_in = '0;
                     ty_in = ty_ff + TYW'(1);
                     srow_in = srow_ff + SAW'(sw_ff);
                     sidx_in = srow_ff + SAW'(sw_ff);
                     tidx_in = tidx_ff + TAW'(1);
                  end
               end else begin
                  tx_in = tx_ff + TXW'(1);
                  sidx_in = sidx_ff + SAW'(1);
                  tidx_in = tidx_ff + TAW'(1);
               end
            end else begin
               tx_in = '0;
               ty_in = '0;
               tidx_in = '0;
               if (32'(x_ff) == 32'(sw_ff) - 32'(tw_ff)) begin
                  if (32'(y_ff) == 32'(sh_ff) - 32'(th_ff)) begin
                     state_in = emts_pkg::ST_RESULT;
                  end else begin
                     x_in = '0;
                     y_in = y_ff + SYW'(1);
                     row_base_in = row_base_ff + SAW'(sw_ff);
                     origin_in = row_base_ff + SAW'(sw_ff);
                     srow_in = row_base_ff + SAW'(sw_ff);
                     sidx_in = row_base_ff + SAW'(sw_ff);
                  end
               end else begin
                  x_in = x_ff + SXW'(1);
                  origin_in = origin_ff + SAW'(1);
                  srow_in = origin_ff + SAW'(1);
                  sidx_in = origin_ff + SAW'(1);
               end
            end
         end
         emts_pkg::ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = emts_pkg::ST_IDLE;
            end
         end
         default: state_in = emts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emts_pkg::ST_IDLE;
         swr_idx_ff <= '0;
         twr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         swr_idx_ff <= swr_idx_in;
         twr_idx_ff <= twr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == emts_pkg::ST_IDLE) begin
         sw_ff <= sw_c;
         sh_ff <= sh_c;
         tw_ff <= tw_c;
         th_ff <= th_c;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      row_base_ff <= row_base_in;
      origin_ff <= origin_in;
      srow_ff <= srow_in;
      sidx_ff <= sidx_in;
      tidx_ff <= tidx_in;
      found_ff <= found_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
   end

   assign rsp_valid = (state_ff == emts_pkg::ST_RESULT);
   assign rsp_found = found_ff;
   assign rsp_match_x = mx_ff;
   assign rsp_match_y = my_ff;

endmodule

// ===== verif/tb_exact_template_match_search.sv =====
module tb_exact_template_match_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1150;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic found;
      logic [emts_pkg::COORD_W-1:0] x;
      logic [emts_pkg::COORD_W-1:0] y;
   } match_type;

   typedef enum logic {ROW_CFG, ROW_PIX} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [emts_pkg::CSR_INDEX_W-1:0] idx;
      logic [emts_pkg::CSR_DATA_W-1:0] data;
      logic op;
      logic [emts_pkg::PIXEL_W-1:0] pixel;
      logic typed;
      match_type res;
   } row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_op;
   logic [emts_pkg::PIXEL_W-1:0] req_pixel;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic [emts_pkg::COORD_W-1:0] rsp_match_x;
   logic [emts_pkg::COORD_W-1:0] rsp_match_y;
   logic csr_valid;
   logic csr_ready;
   logic [emts_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [emts_pkg::CSR_DATA_W-1:0] csr_data;

   exact_template_match_search dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_match_x(rsp_match_x), .rsp_match_y(rsp_match_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   logic [emts_pkg::PIXEL_W-1:0] screen_px[int];
   logic [emts_pkg::PIXEL_W-1:0] tmpl_px[int];
   int unsigned scr_idx;
   int unsigned tpl_idx;
   logic [11:0] reg_sw;
   logic [11:0] reg_sh;
   logic [8:0] reg_tw;
   logic [8:0] reg_th;

   match_type pending_matches[$];
   logic typed_pending;
   match_type typed_res;
   int miss_count;
   int quiet_cycles;
   logic idle_on;
   logic hold_go;
   logic hold_done;
   int hold_left;
   int sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic logic [emts_pkg::PIXEL_W-1:0] scr_at(int unsigned i);
      return screen_px.exists(i) ? screen_px[i] : '0;
   endfunction

   function automatic logic [emts_pkg::PIXEL_W-1:0] tpl_at(int unsigned i);
      return tmpl_px.exists(i) ? tmpl_px[i] : '0;
   endfunction

   function automatic match_type find_first_match();
      int unsigned sw, sh, tw, th;
      bit ok;
      match_type r;
      sw = clamp_dim(reg_sw, emts_pkg::SCREEN_MAX_W_DEF);
      sh = clamp_dim(reg_sh, emts_pkg::SCREEN_MAX_H_DEF);
      tw = clamp_dim(reg_tw, emts_pkg::TEMPLATE_MAX_W_DEF);
      th = clamp_dim(reg_th, emts_pkg::TEMPLATE_MAX_H_DEF);
      r = '0;
      if (tw > sw || th > sh) return r;
      for (int unsigned y = 0; y <= sh - th; y++) begin
         for (int unsigned x = 0; x <= sw - tw; x++) begin
            ok = 1'b1;
            for (int unsigned ty = 0; ty < th && ok; ty++) begin
               for (int unsigned tx = 0; tx < tw && ok; tx++) begin
                  if (scr_at((y + ty) * sw + x + tx) != tpl_at(ty * tw + tx)) ok = 1'b0;
               end
            end
            if (ok) begin
               r.found = 1'b1;
               r.x = x[emts_pkg::COORD_W-1:0];
               r.y = emts_pkg::COORD_W'(sh - th - y);
               return r;
            end
         end
      end
      return r;
   endfunction

   // Returns 1 and the result when the item completes a screen frame.
   function automatic bit predict_pixel(logic op, logic [emts_pkg::PIXEL_W-1:0] pix,
                                        output match_type r);
      int unsigned total;
      r = '0;
      if (op == emts_pkg::OP_TEMPLATE) begin
         tmpl_px[tpl_idx] = pix;
         tpl_idx = (tpl_idx + 1) %
                   (emts_pkg::TEMPLATE_MAX_W_DEF * emts_pkg::TEMPLATE_MAX_H_DEF);
         return 1'b0;
      end
      total = clamp_dim(reg_sw, emts_pkg::SCREEN_MAX_W_DEF) *
              clamp_dim(reg_sh, emts_pkg::SCREEN_MAX_H_DEF);
      screen_px[scr_idx] = pix;
      if (scr_idx + 1 >= total) begin
         r = find_first_match();
         scr_idx = 0;
         tpl_idx = 0;
         return 1'b1;
      end
      scr_idx++;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      match_type want;
      match_type got;
      match_type pred;
      if (reset) begin
         scr_idx = 0;
         tpl_idx = 0;
         reg_sw = 12'd1920;
         reg_sh = 12'd1080;
         reg_tw = 9'd16;
         reg_th = 9'd16;
         miss_count = 0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            got = '{rsp_found, rsp_match_x, rsp_match_y};
            if (pending_matches.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("unexpected result item: found %0d x %0d y %0d",
                     got.found, got.x, got.y);
            end else begin
               want = pending_matches.pop_front();
               if (got.found !== want.found || got.x !== want.x || got.y !== want.y) begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display("result mismatch: expected found %0d x %0d y %0d, got %0d %0d %0d",
                        want.found, want.x, want.y, got.found, got.x, got.y);
               end
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            if (predict_pixel(req_op, req_pixel, pred)) begin
               if (typed_pending) begin
                  pending_matches.push_back(typed_res);
               end else begin
                  pending_matches.push_back(pred);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            quiet_cycles = 0;
            case (csr_index)
               emts_pkg::REG_SCREEN_WIDTH: reg_sw = csr_data;
               emts_pkg::REG_SCREEN_HEIGHT: reg_sh = csr_data;
               emts_pkg::REG_TEMPLATE_WIDTH: reg_tw = csr_data[8:0];
               emts_pkg::REG_TEMPLATE_HEIGHT: reg_th = csr_data[8:0];
               default: ;
            endcase
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
         hold_done = 1'b0;
         hold_left = 0;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall = 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = idle_on && ($urandom_range(0, 99) < 14);
      end
   end

   task automatic send_px(logic op, logic [emts_pkg::PIXEL_W-1:0] pix);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 14) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_op = op;
      req_pixel = pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [emts_pkg::CSR_INDEX_W-1:0] idx,
                            logic [emts_pkg::CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   row_type dir_rows[] = '{
      '{ROW_CFG, emts_pkg::REG_SCREEN_WIDTH, 12'd1,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_SCREEN_HEIGHT, 12'd1,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_WIDTH, 12'd1,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_HEIGHT, 12'd1,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'hFFFFFF, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'hFFFFFF, 1'b1, '{1'b1, 11'd0, 11'd0}},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h000000, 1'b1, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_WIDTH, 12'd4095,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_HEIGHT, 12'd256,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h5A5A5A, 1'b1, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_HEIGHT, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h0F0F0F, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h0F0F0F, 1'b1, '{1'b1, 11'd0, 11'd0}},
      '{ROW_CFG, emts_pkg::REG_SCREEN_WIDTH, 12'd4095,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_SCREEN_HEIGHT, 12'd4095,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'hA5A5A5, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h0F0F0F, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h123456, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_SCREEN_HEIGHT, 12'd2,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h0F0F0F, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_SCREEN_WIDTH, 12'd3,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_CFG, emts_pkg::REG_TEMPLATE_WIDTH, 12'd2,
        emts_pkg::OP_TEMPLATE, 24'h0, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h111111, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_TEMPLATE, 24'h222222, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h333333, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h111111, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h222222, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h111111, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h222222, 1'b0, '0},
      '{ROW_PIX, emts_pkg::REG_SCREEN_WIDTH, 12'd0,
        emts_pkg::OP_SCREEN, 24'h444444, 1'b0, '0}
   };

   initial begin
      int unsigned sw, sh, tw, th, px, py;
      logic [emts_pkg::PIXEL_W-1:0] p0, p1;
      logic [emts_pkg::PIXEL_W-1:0] tp[int];
      logic [emts_pkg::PIXEL_W-1:0] sc[int];
      bit noise, reuse, have_tmpl;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = emts_pkg::OP_TEMPLATE;
      req_pixel = '0;
      csr_valid = 1'b0;
      csr_index = emts_pkg::REG_SCREEN_WIDTH;
      csr_data = '0;
      typed_pending = 1'b0;
      typed_res = '0;
      idle_on = 1'b1;
      hold_go = 1'b0;
      sent = 0;
      have_tmpl = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CFG) begin
            wait_idle();
            csr_write(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            typed_pending = dir_rows[i].typed;
            typed_res = dir_rows[i].res;
            send_px(dir_rows[i].op, dir_rows[i].pixel);
         end
      end
      typed_pending = 1'b0;
      wait_idle();

      // Single-pixel frames give one result item per screen pixel, so a long receiver
      // hold-off backs the block up into its input.
      csr_write(emts_pkg::REG_SCREEN_WIDTH, 12'd1);
      csr_write(emts_pkg::REG_SCREEN_HEIGHT, 12'd1);
      csr_write(emts_pkg::REG_TEMPLATE_WIDTH, 12'd1);
      csr_write(emts_pkg::REG_TEMPLATE_HEIGHT, 12'd1);
      send_px(emts_pkg::OP_TEMPLATE, 24'hC3C3C3);
      hold_go = 1'b1;
      for (int i = 0; i < 30; i++)
         send_px(emts_pkg::OP_SCREEN, (i % 3 == 0) ? 24'hC3C3C3 : 24'($urandom));
      wait_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idle_on = !(sent >= 400 && sent < 650);
         reuse = have_tmpl && ($urandom_range(0, 9) == 0);
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 8);
         if (!reuse) begin
            tw = $urandom_range(1, 4);
            th = $urandom_range(1, 3);
         end
         noise = ($urandom_range(0, 99) < 15);
         p0 = 24'($urandom);
         p1 = 24'($urandom);
         if (!reuse) begin
            tp.delete();
            for (int i = 0; i < tw * th; i++)
               tp[i] = noise ? 24'($urandom) : ($urandom_range(0, 1) ? p0 : p1);
         end
         sc.delete();
         for (int i = 0; i < sw * sh; i++)
            sc[i] = (noise || $urandom_range(0, 3) == 0) ? 24'($urandom) :
                    ($urandom_range(0, 1) ? p0 : p1);
         if (!noise && tw <= sw && th <= sh && $urandom_range(0, 9) < 7) begin
            px = $urandom_range(0, sw - tw);
            py = $urandom_range(0, sh - th);
            for (int ty = 0; ty < th; ty++)
               for (int tx = 0; tx < tw; tx++)
                  sc[(py + ty) * sw + px + tx] = tp[ty * tw + tx];
         end
         csr_write(emts_pkg::REG_SCREEN_WIDTH, emts_pkg::CSR_DATA_W'(sw));
         csr_write(emts_pkg::REG_SCREEN_HEIGHT, emts_pkg::CSR_DATA_W'(sh));
         csr_write(emts_pkg::REG_TEMPLATE_WIDTH, emts_pkg::CSR_DATA_W'(tw));
         csr_write(emts_pkg::REG_TEMPLATE_HEIGHT, emts_pkg::CSR_DATA_W'(th));
         if (!reuse) begin
            for (int i = 0; i < tw * th; i++) send_px(emts_pkg::OP_TEMPLATE, tp[i]);
            have_tmpl = 1'b1;
         end
         for (int i = 0; i < sw * sh; i++) send_px(emts_pkg::OP_SCREEN, sc[i]);
         wait_idle();
      end

      if (miss_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
